// ----- rtl/core/fbc_pkg.sv -----
package fbc_pkg;

   localparam int BYTE_W    = 8;
   localparam int CRC_W     = 16;
   localparam int MAX_SLOTS = 5;
   localparam int SLOT_IDX_W = $clog2(MAX_SLOTS);
   localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);

   localparam logic [BYTE_W-1:0] FLAG_BYTE     = 8'h7E;
   localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY      = 16'h1021;
   localparam logic [CRC_W-1:0]  CRC_HIGH_MASK = 16'hFF00;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } out_slot_type;

endpackage

// ----- rtl/core/fbc_channels.sv -----
interface fbc_req_if
   import fbc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] body_byte;
   logic              last_byte;

   modport source (output valid, output body_byte, output last_byte, input ready);
   modport sink (input valid, input body_byte, input last_byte, output ready);
endinterface

interface fbc_rsp_if
   import fbc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- rtl/core/fbc_crc_fold.sv -----
module fbc_crc_fold
   import fbc_pkg::*;
(
   input  logic [CRC_W-1:0]  crc_seed,
   input  logic [BYTE_W-1:0] data_byte,
   output logic [CRC_W-1:0]  crc_next
);

   always_comb begin
      logic [CRC_W-1:0] c;
      c = crc_seed ^ {data_byte, {(CRC_W-BYTE_W){1'b0}}};
      for (int b = 0; b < BYTE_W; b++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      crc_next = c;
   end

endmodule

// ----- rtl/core/frame_builder_crc16_core.sv -----
// Channel   Direction  Payload
// req_chan  in         body_byte[7:0], last_byte
// rsp_chan  out        out_byte[7:0], out_last
//
// Each accepted body byte expands into one to five output bytes, sent one per cycle
// while rsp_chan is ready. A middle body byte is taken every cycle rsp_chan is ready;
// first and last bytes wait while the single output byte lane sends their extra bytes.
// A new byte is taken in the cycle the previous burst sends its final byte.
// Synchronous active-high reset empties the burst and restarts the CRC at 0xFFFF.
// A stalled output holds its byte and stalls the input behind it.
module frame_builder_crc16_core
   import fbc_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   fbc_req_if.sink   req_chan,
   fbc_rsp_if.source rsp_chan
);

   out_slot_type            slots_ff [MAX_SLOTS];
   out_slot_type            slots_in [MAX_SLOTS];
   logic [SLOT_CNT_W-1:0]   count_ff, count_in;
   logic [CRC_W-1:0]        crc_ff, crc_in;
   logic                    in_frame_ff, in_frame_in;

   logic [CRC_W-1:0]        crc_seed;
   logic [CRC_W-1:0]        crc_folded;
   logic                    req_fire;
   logic                    rsp_fire;

   assign crc_seed = in_frame_ff ? crc_ff : CRC_INIT;

   fbc_crc_fold u_crc_fold (
      .crc_seed  (crc_seed),
      .data_byte (req_chan.body_byte),
      .crc_next  (crc_folded)
   );

   assign rsp_fire = (count_ff != '0) && rsp_chan.ready;
   assign req_chan.ready = (count_ff == '0) ||
                           ((count_ff == SLOT_CNT_W'(1)) && rsp_chan.ready);
   assign req_fire = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid    = (count_ff != '0);
   assign rsp_chan.out_byte = slots_ff[0].data;
   assign rsp_chan.out_last = slots_ff[0].last;

   always_comb begin
      logic [SLOT_IDX_W-1:0] pos;
      pos         = '0;
      slots_in    = slots_ff;
      count_in    = count_ff;
      crc_in      = crc_ff;
      in_frame_in = in_frame_ff;
      if (req_fire) begin
         if (!in_frame_ff) begin
            slots_in[pos] = '{data: FLAG_BYTE, last: 1'b0};
            pos = pos + SLOT_IDX_W'(1);
         end
         slots_in[pos] = '{data: req_chan.body_byte, last: 1'b0};
         pos = pos + SLOT_IDX_W'(1);
         if (req_chan.last_byte) begin
            slots_in[pos] = '{data: crc_folded[CRC_W-1:BYTE_W], last: 1'b0};
            pos = pos + SLOT_IDX_W'(1);
            slots_in[pos] = '{data: crc_folded[BYTE_W-1:0], last: 1'b0};
            pos = pos + SLOT_IDX_W'(1);
            slots_in[pos] = '{data: FLAG_BYTE, last: 1'b1};
         end
         count_in = SLOT_CNT_W'(1) + SLOT_CNT_W'(!in_frame_ff)
                  + (req_chan.last_byte ? SLOT_CNT_W'(3) : SLOT_CNT_W'(0));
         crc_in      = req_chan.last_byte ? CRC_INIT : crc_folded;
         in_frame_in = !req_chan.last_byte;
      end else if (rsp_fire) begin
         for (int i = 0; i < MAX_SLOTS - 1; i++) begin
            slots_in[i] = slots_ff[i+1];
         end
         count_in = count_ff - SLOT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      if (reset) begin
         count_ff    <= '0;
         crc_ff      <= CRC_INIT;
         in_frame_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

// ----- rtl/core/fbc_checker.sv -----
module fbc_checker
   import fbc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] out_byte,
   input logic              out_last
);

   // A stalled result keeps its byte until the transfer completes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(out_last))
      else $error("stalled result changed");

   // Every accepted byte produces a pending result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted byte produced no result");

   // The frame end marker only rides on a flag byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_last |-> out_byte == FLAG_BYTE)
      else $error("end marker on a non-flag byte");

   // With nothing pending the input side is open.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output is empty");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind frame_builder_crc16_core fbc_checker u_fbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .out_byte  (rsp_chan.out_byte),
   .out_last  (rsp_chan.out_last)
);

// ----- tb/sv/tb_frame_builder_crc16_core.sv -----
module tb_frame_builder_crc16_core
   import fbc_pkg::*;
   ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 2000;
   localparam int TARGET_BYTES = 220;
   localparam int TAIL_CYCLES  = 20;

   typedef struct packed {
      logic [BYTE_W-1:0] body_byte;
      logic              last_byte;
   } body_item_type;

   logic clock;
   logic reset;

   fbc_req_if req_chan ();
   fbc_rsp_if rsp_chan ();

   frame_builder_crc16_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   body_item_type pending_bytes[$];
   out_slot_type  tx_expected[$];
   logic [CRC_W-1:0] run_crc = CRC_INIT;
   logic             framing = 1'b0;
   int err_count  = 0;
   int idle_count = 0;
   int gap_left   = 0;
   int burst_left = 0;
   int rx_mode    = 0;
   int rx_phase   = 0;
   int rx_hold    = 0;
   int rx_tick    = 0;

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.body_byte = '0;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready     = 1'b0;
   end

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report(input string msg);
      err_count++;
      $display("ERROR @%0t: %s", $time, msg);
   endtask

   function automatic logic [CRC_W-1:0] crc16_fold(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
      for (int i = 0; i < BYTE_W; i++) begin
         c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // Expands one accepted body byte into the line bytes it produces.
   task automatic frame_expand(input body_item_type it);
      logic [CRC_W-1:0] masked;
      if (!framing) begin
         tx_expected.push_back('{data: FLAG_BYTE, last: 1'b0});
         run_crc = CRC_INIT;
         framing = 1'b1;
      end
      tx_expected.push_back('{data: it.body_byte, last: 1'b0});
      run_crc = crc16_fold(run_crc, it.body_byte);
      if (it.last_byte) begin
         masked = (run_crc & CRC_HIGH_MASK) >> BYTE_W;
         tx_expected.push_back('{data: masked[BYTE_W-1:0], last: 1'b0});
         tx_expected.push_back('{data: run_crc[BYTE_W-1:0], last: 1'b0});
         tx_expected.push_back('{data: FLAG_BYTE, last: 1'b1});
         run_crc = CRC_INIT;
         framing = 1'b0;
      end
   endtask

   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
      pending_bytes.push_back('{body_byte: b, last_byte: last});
   endtask

   function automatic logic [BYTE_W-1:0] random_byte();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return FLAG_BYTE;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_random_frame(input int len);
      for (int i = 0; i < len; i++) begin
         push_byte(random_byte(), i == len - 1);
      end
   endtask

   always @(posedge clock) begin : drive
      logic took;
      took = req_chan.valid && req_chan.ready;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (took) begin
            void'(pending_bytes.pop_front());
         end
         if (req_chan.valid && !took) begin
            // Hold the current byte until the block takes it.
         end else if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            req_chan.valid     <= 1'b1;
            req_chan.body_byte <= pending_bytes[0].body_byte;
            req_chan.last_byte <= pending_bytes[0].last_byte;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : sink_ready
      logic nr;
      nr = 1'b1;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rx_phase == 0) begin
            rx_mode  = $urandom_range(0, 3);
            rx_phase = $urandom_range(40, 160);
         end else begin
            rx_phase--;
         end
         rx_tick++;
         case (rx_mode)
            0: nr = 1'b1;
            1: nr = ($urandom_range(0, 9) < 7);
            2: nr = (rx_tick % 3 != 0);
            default: begin
               if (rx_hold > 0) begin
                  rx_hold--;
                  nr = 1'b0;
               end else begin
                  nr = 1'b1;
                  if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 12);
               end
            end
         endcase
         rsp_chan.ready <= nr;
      end
   end

   // Input transfers are predicted before output transfers of the same edge are checked.
   always @(posedge clock) begin : watch
      out_slot_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            frame_expand('{body_byte: req_chan.body_byte, last_byte: req_chan.last_byte});
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (tx_expected.size() == 0) begin
               report($sformatf("unexpected output byte %02h last %0b",
                                rsp_chan.out_byte, rsp_chan.out_last));
            end else begin
               want = tx_expected.pop_front();
               if (rsp_chan.out_byte !== want.data) begin
                  report($sformatf("out_byte %02h, expected %02h",
                                   rsp_chan.out_byte, want.data));
               end
               if (rsp_chan.out_last !== want.last) begin
                  report($sformatf("out_last %0b, expected %0b on byte %02h",
                                   rsp_chan.out_last, want.last, want.data));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_count <= 0;
      end else if (idle_count >= IDLE_LIMIT) begin
         $display("ERROR @%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   initial begin
      int len;
      // Single-byte frames at both extremes.
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      // Flag values inside the body pass through unstuffed.
      push_byte(FLAG_BYTE, 1'b0);
      push_byte(FLAG_BYTE, 1'b1);
      // The standard check string, whose CRC is 0x29B1.
      for (int i = 0; i < 9; i++) begin
         push_byte(BYTE_W'(8'h31 + i), i == 8);
      end
      // A frame shorter than the address and control fields.
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hAA, 1'b1);
      // Address, control and a short payload.
      push_byte(8'h01, 1'b0);
      push_byte(8'h02, 1'b0);
      push_byte(8'h03, 1'b0);
      push_byte(8'h04, 1'b0);
      push_byte(8'h13, 1'b0);
      push_byte(8'h55, 1'b0);
      push_byte(8'hC3, 1'b1);

      while (pending_bytes.size() < TARGET_BYTES) begin
         case ($urandom_range(0, 9))
            0, 1:    len = $urandom_range(1, 4);
            2:       len = ($urandom_range(0, 2) == 0) ? $urandom_range(30, 60)
                                                       : $urandom_range(5, 16);
            default: len = $urandom_range(5, 16);
         endcase
         push_random_frame(len);
      end

      @(negedge reset);
      while (pending_bytes.size() != 0) @(posedge clock);
      while (tx_expected.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tx_expected.size() != 0) begin
         report($sformatf("%0d expected bytes never sent", tx_expected.size()));
      end
      if (err_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
